[rtl/qs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers for the quicksort engine.
// Used by the sorter core, the top level and the port checker.
package qs_pkg;

  localparam int MAX_ELEMENTS  = 1024;
  localparam int STACK_ENTRIES = 16;
  localparam int VALUE_BITS    = 32;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int POS_W = IDX_W + 2;
  localparam int SP_W  = $clog2(STACK_ENTRIES + 1);
  localparam int SPI_W = $clog2(STACK_ENTRIES);

  // Fixed field widths of the stream channels
  localparam int DATA_W      = 32;
  localparam int IN_IDX_W    = 10;
  localparam int OUT_CNT_W   = 11;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - OUT_CNT_W;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;

  typedef logic signed [VALUE_BITS-1:0] elem_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic signed [POS_W-1:0]      pos_t;
  typedef logic [SP_W-1:0]              sp_t;

  localparam pos_t POS_ONE = pos_t'(1);

  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    elem_t wdata;
    idx_t  raddr;
  } mem_req_t;

  typedef struct packed {
    logic start;
    cnt_t count;
  } sort_cmd_t;

  // Wrap a 32-bit loaded value to the element width, sign-extended
  function automatic elem_t to_elem(input logic [DATA_W-1:0] raw);
    logic signed [63:0] wide;
    wide = 64'($signed(raw));
    return wide[VALUE_BITS-1:0];
  endfunction

  // Low 32 bits of the sign-extended element
  function automatic logic [DATA_W-1:0] to_out(input elem_t e);
    logic signed [63:0] wide;
    wide = 64'(e);
    return wide[DATA_W-1:0];
  endfunction

endpackage

[rtl/qs_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module qs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/qs_sorter.sv]
`timescale 1ns / 1ps
// Quicksort sequencer: Hoare partition around the middle element, range stack,
// insertion-sort fallback when the stack is full. Uses qs_pkg; drives the RAM port.
module qs_sorter import qs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sort_cmd_t cmd,
  output logic      done,
  output mem_req_t  mreq,
  input  elem_t     rdata
);

  localparam int SS_W = 4;
  localparam logic [SS_W-1:0] S_IDLE   = 4'd0;
  localparam logic [SS_W-1:0] S_PIV    = 4'd1;
  localparam logic [SS_W-1:0] S_PIVW   = 4'd2;
  localparam logic [SS_W-1:0] S_ICMP   = 4'd3;
  localparam logic [SS_W-1:0] S_JCMP   = 4'd4;
  localparam logic [SS_W-1:0] S_SWAPJ  = 4'd5;
  localparam logic [SS_W-1:0] S_END    = 4'd6;
  localparam logic [SS_W-1:0] S_IS_X   = 4'd7;
  localparam logic [SS_W-1:0] S_IS_CMP = 4'd8;

  logic [SS_W-1:0] state_r, state_nxt;
  pos_t  lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  pos_t  ins_lo_r, ins_lo_nxt, ins_hi_r, ins_hi_nxt;
  elem_t pivot_r, pivot_nxt, aval_r, aval_nxt;
  sp_t   sp_r, sp_nxt;
  logic  done_r, done_nxt;
  range_t stk_r [STACK_ENTRIES];

  pos_t   mid_sum, mid, i_inc, j_dec, j_inc;
  pos_t   slo, shi, blo, bhi, blo_inc;
  logic   lv, rv, left_small, sp_full;
  sp_t    sp_dec;
  range_t top_ent;
  logic   push;

  assign mid_sum    = lo_r + hi_r;
  assign mid        = mid_sum >>> 1;
  assign i_inc      = i_r + POS_ONE;
  assign j_dec      = j_r - POS_ONE;
  assign j_inc      = j_r + POS_ONE;
  assign lv         = lo_r < j_r;
  assign rv         = i_r < hi_r;
  assign left_small = (j_r - lo_r) <= (hi_r - i_r);
  assign slo        = left_small ? lo_r : i_r;
  assign shi        = left_small ? j_r  : hi_r;
  assign blo        = left_small ? i_r  : lo_r;
  assign bhi        = left_small ? hi_r : j_r;
  assign blo_inc    = blo + POS_ONE;
  assign sp_full    = sp_r == SP_W'(STACK_ENTRIES);
  assign sp_dec     = sp_r - SP_W'(1);
  assign top_ent    = stk_r[sp_dec[SPI_W-1:0]];

  always_comb begin
    state_nxt  = state_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ins_lo_nxt = ins_lo_r;
    ins_hi_nxt = ins_hi_r;
    pivot_nxt  = pivot_r;
    aval_nxt   = aval_r;
    sp_nxt     = sp_r;
    done_nxt   = 1'b0;
    push       = 1'b0;
    mreq       = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          lo_nxt = '0;
          hi_nxt = pos_t'(cmd.count) - POS_ONE;
          sp_nxt = '0;
          if (cmd.count < CNT_W'(2)) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_PIV;
          end
        end
      end
      S_PIV: begin
        mreq.raddr = mid[IDX_W-1:0];
        i_nxt      = lo_r;
        j_nxt      = hi_r;
        state_nxt  = S_PIVW;
      end
      S_PIVW: begin
        pivot_nxt  = rdata;
        mreq.raddr = i_r[IDX_W-1:0];
        state_nxt  = S_ICMP;
      end
      S_ICMP: begin
        if (i_r <= hi_r && rdata < pivot_r) begin
          i_nxt      = i_inc;
          mreq.raddr = i_inc[IDX_W-1:0];
        end else begin
          aval_nxt   = rdata;
          mreq.raddr = j_r[IDX_W-1:0];
          state_nxt  = S_JCMP;
        end
      end
      S_JCMP: begin
        if (j_r >= lo_r && pivot_r < rdata) begin
          j_nxt      = j_dec;
          mreq.raddr = j_dec[IDX_W-1:0];
        end else if (i_r <= j_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = i_r[IDX_W-1:0];
          mreq.wdata = rdata;
          state_nxt  = S_SWAPJ;
        end else begin
          state_nxt = S_END;
        end
      end
      S_SWAPJ: begin
        mreq.we    = 1'b1;
        mreq.waddr = j_r[IDX_W-1:0];
        mreq.wdata = aval_r;
        i_nxt      = i_inc;
        j_nxt      = j_dec;
        if (i_inc <= j_dec) begin
          mreq.raddr = i_inc[IDX_W-1:0];
          state_nxt  = S_ICMP;
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (lv && rv) begin
          lo_nxt = slo;
          hi_nxt = shi;
          if (!sp_full) begin
            push      = 1'b1;
            sp_nxt    = sp_r + SP_W'(1);
            state_nxt = S_PIV;
          end else begin
            // stack full: sort the larger side in place right now
            ins_lo_nxt = blo;
            ins_hi_nxt = bhi;
            i_nxt      = blo_inc;
            mreq.raddr = blo_inc[IDX_W-1:0];
            state_nxt  = S_IS_X;
          end
        end else if (lv) begin
          hi_nxt    = j_r;
          state_nxt = S_PIV;
        end else if (rv) begin
          lo_nxt    = i_r;
          state_nxt = S_PIV;
        end else if (sp_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          sp_nxt    = sp_dec;
          lo_nxt    = pos_t'(top_ent.lo);
          hi_nxt    = pos_t'(top_ent.hi);
          state_nxt = S_PIV;
        end
      end
      S_IS_X: begin
        aval_nxt   = rdata;
        j_nxt      = i_r - POS_ONE;
        mreq.raddr = j_nxt[IDX_W-1:0];
        state_nxt  = S_IS_CMP;
      end
      S_IS_CMP: begin
        mreq.we    = 1'b1;
        mreq.waddr = j_inc[IDX_W-1:0];
        if (j_r >= ins_lo_r && aval_r < rdata) begin
          // shift the larger element up one place
          mreq.wdata = rdata;
          j_nxt      = j_dec;
          mreq.raddr = j_dec[IDX_W-1:0];
        end else begin
          mreq.wdata = aval_r;
          i_nxt      = i_inc;
          if (i_inc <= ins_hi_r) begin
            mreq.raddr = i_inc[IDX_W-1:0];
            state_nxt  = S_IS_X;
          end else begin
            state_nxt = S_PIV;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    ins_lo_r <= ins_lo_nxt;
    ins_hi_r <= ins_hi_nxt;
    pivot_r  <= pivot_nxt;
    aval_r   <= aval_nxt;
    if (push) begin
      stk_r[sp_r[SPI_W-1:0]] <= '{lo: blo[IDX_W-1:0], hi: bhi[IDX_W-1:0]};
    end
  end

  assign done = done_r;

endmodule

[rtl/quicksort_engine.sv]
`timescale 1ns / 1ps
// Quicksort engine top level: load/read request stream in, result stream out.
// Uses qs_pkg, qs_ram (element store) and qs_sorter (partition sequencer).
//
// Usage:
//  Input transfers carry req_type in in_tuser (load or read), the final-load
//  mark in in_tlast and value/index in in_tdata. A load writes one element
//  and returns nothing; a load past capacity is dropped and
//  flagged. The load with tlast set closes the batch and starts an in-place
//  ascending quicksort; when it finishes, one done result carries the element
//  count and status (overflow if any load of the batch was dropped). The next
//  load after a done result starts a fresh batch.
//  A read returns the element at the index, or a range error status if the
//  index is at or past the count. A read in range passes the READ and RESP
//  states; one out of range goes straight to RESP. Sort time is set by the
//  single RAM read port shared by both scans. in_tready is low while a read
//  or sort is in flight, so one item is worked at a time.
//  Results wait in an output register: a stalled receiver holds the result
//  and only blocks the next item that produces one. Reset empties the batch
//  (count and overflow cleared); the element store itself is not cleared.
module quicksort_engine import qs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value, [41:32] index, rest zero
  input  logic                   in_tuser,   // [0] req_type
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] value_res, [42:32] count, rest zero
  output logic [STAT_W-1:0]      out_tuser   // [1:0] status
);

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
  localparam logic [ST_W-1:0] ST_READ = 2'd1;
  localparam logic [ST_W-1:0] ST_SORT = 2'd2;
  localparam logic [ST_W-1:0] ST_RESP = 2'd3;

  logic [ST_W-1:0] state_r, state_nxt;
  cnt_t  cnt_r, cnt_nxt;
  logic  ovf_r, ovf_nxt;
  logic  closed_r, closed_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic [DATA_W-1:0]   in_value;
  logic [IN_IDX_W-1:0] in_index;
  logic      in_xfer, out_free;
  cnt_t      base_cnt;
  logic      room;
  logic      base_ovf;
  mem_req_t  top_req, sort_req, ram_req;
  elem_t     ram_rdata;
  logic [VALUE_BITS-1:0] ram_q;
  sort_cmd_t sort_cmd;
  logic      sort_done;

  assign in_value = in_tdata[DATA_W-1:0];
  assign in_index = in_tdata[DATA_W+IN_IDX_W-1:DATA_W];
  assign in_tready = state_r == ST_IDLE;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // first load after a done result starts a new batch
  assign base_cnt = closed_r ? '0 : cnt_r;
  assign base_ovf = closed_r ? 1'b0 : ovf_r;
  assign room     = base_cnt < CNT_W'(MAX_ELEMENTS);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    closed_nxt    = closed_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    top_req       = '0;
    sort_cmd      = '0;
    top_req.waddr = base_cnt[IDX_W-1:0];
    top_req.wdata = to_elem(in_value);
    top_req.raddr = IDX_W'(in_index);
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == REQ_LOAD) begin
            top_req.we = room;
            cnt_nxt    = room ? base_cnt + CNT_W'(1) : base_cnt;
            ovf_nxt    = base_ovf || !room;
            closed_nxt = in_tlast;
            if (in_tlast) begin
              sort_cmd.start = 1'b1;
              sort_cmd.count = cnt_nxt;
              state_nxt      = ST_SORT;
            end
          end else if (32'(in_index) < 32'(cnt_r)) begin
            res_stat_nxt = STAT_OK;
            state_nxt    = ST_READ;
          end else begin
            res_val_nxt  = '0;
            res_stat_nxt = STAT_RANGE;
            state_nxt    = ST_RESP;
          end
        end
      end
      ST_READ: begin
        res_val_nxt = to_out(ram_rdata);
        state_nxt   = ST_RESP;
      end
      ST_SORT: begin
        if (sort_done) begin
          res_val_nxt  = '0;
          res_stat_nxt = ovf_r ? STAT_OVF : STAT_OK;
          state_nxt    = ST_RESP;
        end
      end
      ST_RESP: begin
        // hold here until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_cnt_nxt   = OUT_CNT_W'(cnt_r);
          out_stat_nxt  = res_stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // sorter owns the RAM port while a sort runs
  assign ram_req = (state_r == ST_SORT) ? sort_req : top_req;

  qs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_q)
  );

  assign ram_rdata = elem_t'(ram_q);

  qs_sorter u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (sort_cmd),
    .done  (sort_done),
    .mreq  (sort_req),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_val_r};
  assign out_tuser  = out_stat_r;

endmodule

[rtl/qs_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the quicksort engine, bound to the top level.
// Uses qs_pkg for field widths and status codes.
module qs_checker import qs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a read leaves the block busy in the cycle after its transfer
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_READ |=> !in_tready)
    else $error("ready right after a read transfer");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_RANGE |-> out_tdata[DATA_W-1:0] == '0)
    else $error("range error carries a value");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[DATA_W+OUT_CNT_W-1:DATA_W]) <= MAX_ELEMENTS)
    else $error("count above capacity");

  // overflow only happens on a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_OVF |->
      32'(out_tdata[DATA_W+OUT_CNT_W-1:DATA_W]) == MAX_ELEMENTS)
    else $error("overflow status without a full store");

endmodule

bind quicksort_engine qs_checker u_qs_checker (.*);
